// File: sv/assert_macros.svh
// Assertion macros for the checker of the occupancy grid.
// No dependencies; take it in by `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while rst is high.
`define DOG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define DOG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/dog_pkg.sv
// Shared types, constants and command/status structs of the occupancy grid.
// No dependencies; every file but assert_macros.svh imports it.
package dog_pkg;

   localparam int MAX_ROWS   = 16;
   localparam int MAX_COLS   = 16;
   localparam int VALUE_W    = 24;
   localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int SWEEP_W    = $clog2(CELL_COUNT + 1);

   localparam int DIM_W      = 5;
   localparam int POS_W      = 4;
   localparam int PIX_W      = 12;
   localparam int BOX_W      = 16;
   localparam int DECAY_W    = 17;
   localparam int DECAY_FRAC = 16;
   localparam int CSR_IDX_W  = 2;

   // foot point and divider widths
   localparam int FXR_W      = BOX_W + 2;
   localparam int FYR_W      = BOX_W + 6;
   localparam int FX_W       = PIX_W + 5;
   localparam int FY_W       = PIX_W + 9;
   localparam int NUM_W      = FY_W + DIM_W;
   localparam int DEN_W      = FY_W;
   localparam int QUO_W      = POS_W;
   localparam int SH_W       = DEN_W + QUO_W - 1;
   localparam int DIV_STEPS  = QUO_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int FOOT_Y_SCALE = 320;

   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
   localparam logic [VALUE_W-1:0] VALUE_ONE = VALUE_W'(256);
   localparam logic [DECAY_W-1:0] DECAY_ONE = DECAY_W'(65536);

   localparam logic [DIM_W-1:0]   GRID_ROWS_RST = DIM_W'(8);
   localparam logic [DIM_W-1:0]   GRID_COLS_RST = DIM_W'(8);
   localparam logic [DECAY_W-1:0] DECAY_RST     = DECAY_W'(60293);

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_FACTOR = 2'd2;

   typedef enum logic [1:0] {
      KIND_FRAME,
      KIND_TRACK,
      KIND_READ,
      KIND_SKIP
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECAY,
      ST_TRK_PREP,
      ST_TRK_LOAD,
      ST_TRK_DIV,
      ST_TRK_RD,
      ST_TRK_WR,
      ST_IGNORE,
      ST_QRY_RD,
      ST_QRY_OUT
   } state_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_CLEAR,
      MEM_DECAY,
      MEM_RD_TRACK,
      MEM_RD_QUERY,
      MEM_INC
   } mem_op_type;

   typedef enum logic [1:0] {
      OUT_IGNORE,
      OUT_TRACK,
      OUT_READ
   } out_src_type;

   typedef struct packed {
      logic        capture;
      logic        frame_arm;
      logic        frame_disarm;
      logic        foot_load;
      logic        div_load;
      logic        div_step;
      mem_op_type  mem_op;
      logic        out_load;
      out_src_type out_src;
   } cmd_type;

   typedef struct packed {
      kind_type req_kind;
      logic     req_frame_bad;
      logic     req_id_neg;
      logic     armed;
      logic     out_free;
      logic     sweep_last;
      logic     sweep_end;
   } status_type;

endpackage

// File: sv/decaying_occupancy_grid_core.sv
// Top level of the decaying occupancy grid: controller plus datapath.
// Depends on dog_pkg, dog_ctrl, dog_datapath (and dog_qdiv below it).
//
// Keeps a 16x16 grid of Q16.8 occupancy counts in a single-port-read, single-port-write
// memory. After reset the block runs a clearing pass over all 256 cells, one cell a cycle,
// with req_stall high; csr writes are taken during it. Requests are handled one at a
// time by the controller. Their steps, from acceptance to the next acceptance:
// a frame request with non-zero size: one memory sweep that reads cell n and
// writes back cell n-1 each cycle, decayed by the Q1.16 factor; a frame with zero
// width or height, and kind 3, end at acceptance; a counted track: foot point clamp,
// operand setup, four steps of the two restoring dividers that give column and row,
// memory read, increment and write; an ignored track: hand-over; a read: read, hand-over.
// Results wait in an output register, so a new request is taken while an older result
// is still stalled; only the step that hands over the next result waits for it.
// Rows or columns set to zero act as one, above 16 as 16; a decay factor above
// 65536 acts as 1.0. Change configuration only while no request is in flight.
module decaying_occupancy_grid_core (
   input  logic                            clock,
   input  logic                            reset,
   // configuration writes
   input  logic                            csr_we,
   input  logic [dog_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dog_pkg::DECAY_W-1:0]     csr_wdata,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_kind,
   input  logic [dog_pkg::PIX_W-1:0]       req_frame_width,
   input  logic [dog_pkg::PIX_W-1:0]       req_frame_height,
   input  logic signed [dog_pkg::BOX_W-1:0] req_track_id,
   input  logic signed [dog_pkg::BOX_W-1:0] req_box_x,
   input  logic signed [dog_pkg::BOX_W-1:0] req_box_y,
   input  logic signed [dog_pkg::BOX_W-1:0] req_box_w,
   input  logic signed [dog_pkg::BOX_W-1:0] req_box_h,
   input  logic [dog_pkg::POS_W-1:0]       req_query_row,
   input  logic [dog_pkg::POS_W-1:0]       req_query_col,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dog_pkg::POS_W-1:0]       rsp_cell_row,
   output logic [dog_pkg::POS_W-1:0]       rsp_cell_col,
   output logic [dog_pkg::VALUE_W-1:0]     rsp_cell_value,
   output logic                            rsp_counted,
   output logic                            rsp_saturated
);
   import dog_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing: one request in flight, stall held outside the idle state
   dog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and arithmetic
   dog_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_kind         (req_kind),
      .req_frame_width  (req_frame_width),
      .req_frame_height (req_frame_height),
      .req_track_id     (req_track_id),
      .req_box_x        (req_box_x),
      .req_box_y        (req_box_y),
      .req_box_w        (req_box_w),
      .req_box_h        (req_box_h),
      .req_query_row    (req_query_row),
      .req_query_col    (req_query_col),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_cell_row     (rsp_cell_row),
      .rsp_cell_col     (rsp_cell_col),
      .rsp_cell_value   (rsp_cell_value),
      .rsp_counted      (rsp_counted),
      .rsp_saturated    (rsp_saturated),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// File: sv/dog_qdiv.sv
// Restoring divider, one quotient bit per step, MSB first.
// Depends on dog_pkg; the quotient must be known to fit in QUO_W bits.
module dog_qdiv (
   input  logic                        clock,
   input  logic                        load,
   input  logic                        step,
   input  logic [dog_pkg::NUM_W-1:0]   num,
   input  logic [dog_pkg::DEN_W-1:0]   den,
   output logic [dog_pkg::QUO_W-1:0]   quo
);
   import dog_pkg::*;

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [SH_W-1:0]  dsh_ff, dsh_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic             fits;

   always_comb begin
      fits   = rem_ff >= NUM_W'(dsh_ff);
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      if (load) begin
         rem_in = num;
         dsh_in = SH_W'(den) << (QUO_W - 1);
         quo_in = '0;
      end else if (step) begin
         if (fits) begin
            rem_in = rem_ff - NUM_W'(dsh_ff);
         end
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[QUO_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

// File: sv/dog_datapath.sv
// Datapath: config registers, frame state, foot point math, cell memory, result register.
// Depends on dog_pkg and dog_qdiv; driven by dog_ctrl through cmd_type.
module dog_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [dog_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dog_pkg::DECAY_W-1:0]   csr_wdata,
   input  logic [1:0]                    req_kind,
   input  logic [dog_pkg::PIX_W-1:0]     req_frame_width,
   input  logic [dog_pkg::PIX_W-1:0]     req_frame_height,
   input  logic signed [dog_pkg::BOX_W-1:0] req_track_id,
   input  logic signed [dog_pkg::BOX_W-1:0] req_box_x,
   input  logic signed [dog_pkg::BOX_W-1:0] req_box_y,
   input  logic signed [dog_pkg::BOX_W-1:0] req_box_w,
   input  logic signed [dog_pkg::BOX_W-1:0] req_box_h,
   input  logic [dog_pkg::POS_W-1:0]     req_query_row,
   input  logic [dog_pkg::POS_W-1:0]     req_query_col,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [dog_pkg::POS_W-1:0]     rsp_cell_row,
   output logic [dog_pkg::POS_W-1:0]     rsp_cell_col,
   output logic [dog_pkg::VALUE_W-1:0]   rsp_cell_value,
   output logic                          rsp_counted,
   output logic                          rsp_saturated,
   input  dog_pkg::cmd_type              cmd,
   output dog_pkg::status_type           status
);
   import dog_pkg::*;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

   function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p,
                                                  input logic [DIM_W-1:0] last);
      logic [POS_W-1:0] r;
      r = p;
      if ({1'b0, p} > last) begin
         r = last[POS_W-1:0];
      end
      return r;
   endfunction

   // configuration
   logic [DIM_W-1:0]   rows_ff, cols_ff;
   logic [DECAY_W-1:0] decay_ff;
   logic [DIM_W-1:0]   rows_eff, cols_eff, rows_last, cols_last;
   logic [DECAY_W-1:0] decay_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= GRID_ROWS_RST;
         cols_ff  <= GRID_COLS_RST;
         decay_ff <= DECAY_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_ROWS:    rows_ff  <= csr_wdata[DIM_W-1:0];
            CSR_GRID_COLS:    cols_ff  <= csr_wdata[DIM_W-1:0];
            CSR_DECAY_FACTOR: decay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      rows_eff  = clamp_dim(rows_ff, DIM_W'(MAX_ROWS));
      cols_eff  = clamp_dim(cols_ff, DIM_W'(MAX_COLS));
      rows_last = rows_eff - DIM_W'(1);
      cols_last = cols_eff - DIM_W'(1);
      decay_eff = (decay_ff > DECAY_ONE) ? DECAY_ONE : decay_ff;
   end

   // frame state
   logic             armed_ff;
   logic [PIX_W-1:0] cur_w_ff, cur_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
      end else if (cmd.frame_arm) begin
         armed_ff <= 1'b1;
      end else if (cmd.frame_disarm) begin
         armed_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.frame_arm) begin
         cur_w_ff <= req_frame_width;
         cur_h_ff <= req_frame_height;
      end
   end

   // captured request
   logic signed [BOX_W-1:0] box_x_ff, box_y_ff, box_w_ff, box_h_ff;
   logic [POS_W-1:0]        qrow_ff, qcol_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         box_x_ff <= req_box_x;
         box_y_ff <= req_box_y;
         box_w_ff <= req_box_w;
         box_h_ff <= req_box_h;
         qrow_ff  <= req_query_row;
         qcol_ff  <= req_query_col;
      end
   end

   // foot point: x in 1/32 pixel, y in 1/320 pixel, clamped into the frame
   logic signed [FXR_W-1:0] fx_raw;
   logic signed [FYR_W-1:0] fy_raw;
   logic [FX_W-1:0]         fx_hi, fx_cl, fx_ff;
   logic [FY_W-1:0]         fy_hi, fy_cl, fy_ff;

   always_comb begin
      fx_raw = (FXR_W'(box_x_ff) <<< 1) + FXR_W'(box_w_ff);
      fy_raw = FYR_W'(box_y_ff) * FYR_W'(20) + FYR_W'(box_h_ff) * FYR_W'(19);
      fx_hi  = {cur_w_ff - PIX_W'(1), 5'b0};
      fy_hi  = FY_W'(cur_h_ff - PIX_W'(1)) * FY_W'(FOOT_Y_SCALE);
      if (fx_raw[FXR_W-1]) begin
         fx_cl = '0;
      end else if (fx_raw > $signed({1'b0, fx_hi})) begin
         fx_cl = fx_hi;
      end else begin
         fx_cl = fx_raw[FX_W-1:0];
      end
      if (fy_raw[FYR_W-1]) begin
         fy_cl = '0;
      end else if (fy_raw > $signed({1'b0, fy_hi})) begin
         fy_cl = fy_hi;
      end else begin
         fy_cl = fy_raw[FY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.foot_load) begin
         fx_ff <= fx_cl;
         fy_ff <= fy_cl;
      end
   end

   // cell index: col = fx*cols / (w*32), row = fy*rows / (h*320)
   logic [NUM_W-1:0] num_x, num_y;
   logic [DEN_W-1:0] den_x, den_y;
   logic [QUO_W-1:0] quo_x, quo_y;

   always_comb begin
      num_x = NUM_W'(fx_ff) * NUM_W'(cols_eff);
      num_y = NUM_W'(fy_ff) * NUM_W'(rows_eff);
      den_x = DEN_W'({cur_w_ff, 5'b0});
      den_y = DEN_W'(cur_h_ff) * DEN_W'(FOOT_Y_SCALE);
   end

   dog_qdiv u_div_col (
      .clock (clock),
      .load  (cmd.div_load),
      .step  (cmd.div_step),
      .num   (num_x),
      .den   (den_x),
      .quo   (quo_x)
   );

   dog_qdiv u_div_row (
      .clock (clock),
      .load  (cmd.div_load),
      .step  (cmd.div_step),
      .num   (num_y),
      .den   (den_y),
      .quo   (quo_y)
   );

   logic [POS_W-1:0] trk_row, trk_col, qry_row, qry_col;
   logic [POS_W-1:0] cell_row_ff, cell_col_ff;

   always_comb begin
      trk_row = clamp_pos(quo_y, rows_last);
      trk_col = clamp_pos(quo_x, cols_last);
      qry_row = clamp_pos(qrow_ff, rows_last);
      qry_col = clamp_pos(qcol_ff, cols_last);
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_op == MEM_RD_TRACK) begin
         cell_row_ff <= trk_row;
         cell_col_ff <= trk_col;
      end else if (cmd.mem_op == MEM_RD_QUERY) begin
         cell_row_ff <= qry_row;
         cell_col_ff <= qry_col;
      end
   end

   // cell memory, one read and one write port, registered read
   logic [VALUE_W-1:0] mem [CELL_COUNT];
   logic [VALUE_W-1:0] rd_data_ff;
   logic               rd_en, wr_en;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [SWEEP_W-1:0] sweep_ff, sweep_in, sweep_prev;
   logic [VALUE_W+DECAY_W-1:0] decay_prod;
   logic [VALUE_W-1:0] decayed;
   logic [VALUE_W:0]   inc_sum;
   logic               inc_sat;
   logic [VALUE_W-1:0] inc_val;

   always_comb begin
      sweep_prev = sweep_ff - SWEEP_W'(1);
      decay_prod = (VALUE_W+DECAY_W)'(rd_data_ff) * (VALUE_W+DECAY_W)'(decay_eff);
      decayed    = decay_prod[VALUE_W+DECAY_FRAC-1:DECAY_FRAC];
      inc_sum    = {1'b0, rd_data_ff} + (VALUE_W+1)'(VALUE_ONE);
      inc_sat    = inc_sum >= {1'b0, VALUE_MAX};
      inc_val    = inc_sat ? VALUE_MAX : inc_sum[VALUE_W-1:0];

      rd_en   = 1'b0;
      wr_en   = 1'b0;
      rd_addr = sweep_ff[ADDR_W-1:0];
      wr_addr = sweep_ff[ADDR_W-1:0];
      wr_data = '0;
      case (cmd.mem_op)
         MEM_CLEAR: begin
            wr_en = 1'b1;
         end
         MEM_DECAY: begin
            // read cell n while writing back cell n-1
            rd_en   = sweep_ff != SWEEP_W'(CELL_COUNT);
            wr_en   = sweep_ff != '0;
            wr_addr = sweep_prev[ADDR_W-1:0];
            wr_data = decayed;
         end
         MEM_RD_TRACK: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(ADDR_W'(trk_row) * ADDR_W'(MAX_COLS) + ADDR_W'(trk_col));
         end
         MEM_RD_QUERY: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(ADDR_W'(qry_row) * ADDR_W'(MAX_COLS) + ADDR_W'(qry_col));
         end
         MEM_INC: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(ADDR_W'(cell_row_ff) * ADDR_W'(MAX_COLS)
                              + ADDR_W'(cell_col_ff));
            wr_data = inc_val;
         end
         default: ;
      endcase
      sweep_in = (cmd.mem_op == MEM_CLEAR || cmd.mem_op == MEM_DECAY)
                 ? sweep_ff + SWEEP_W'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // result register
   logic               rsp_valid_ff;
   logic [POS_W-1:0]   rsp_row_ff, rsp_col_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_counted_ff, rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         case (cmd.out_src)
            OUT_TRACK: begin
               rsp_row_ff     <= cell_row_ff;
               rsp_col_ff     <= cell_col_ff;
               rsp_value_ff   <= inc_val;
               rsp_counted_ff <= 1'b1;
               rsp_sat_ff     <= inc_sat;
            end
            OUT_READ: begin
               rsp_row_ff     <= cell_row_ff;
               rsp_col_ff     <= cell_col_ff;
               rsp_value_ff   <= rd_data_ff;
               rsp_counted_ff <= 1'b0;
               rsp_sat_ff     <= 1'b0;
            end
            default: begin
               rsp_row_ff     <= '0;
               rsp_col_ff     <= '0;
               rsp_value_ff   <= '0;
               rsp_counted_ff <= 1'b0;
               rsp_sat_ff     <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_row   = rsp_row_ff;
   assign rsp_cell_col   = rsp_col_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_counted    = rsp_counted_ff;
   assign rsp_saturated  = rsp_sat_ff;

   always_comb begin
      status.req_kind      = kind_type'(req_kind);
      status.req_frame_bad = (req_frame_width == '0) || (req_frame_height == '0);
      status.req_id_neg    = req_track_id[BOX_W-1];
      status.armed         = armed_ff;
      status.out_free      = !rsp_valid_ff || !rsp_stall;
      status.sweep_last    = sweep_ff == SWEEP_W'(CELL_COUNT - 1);
      status.sweep_end     = sweep_ff == SWEEP_W'(CELL_COUNT);
   end

endmodule

// File: sv/dog_ctrl.sv
// Controller state machine: sequences clear, decay sweep, track and read steps.
// Depends on dog_pkg; talks to dog_datapath only through cmd_type and status_type.
module dog_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dog_pkg::status_type status,
   output dog_pkg::cmd_type    cmd
);
   import dog_pkg::*;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_stall  = state_ff != ST_IDLE;
      case (state_ff)
         ST_CLEAR: begin
            cmd.mem_op = MEM_CLEAR;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (status.req_kind)
                  KIND_FRAME: begin
                     if (status.req_frame_bad) begin
                        cmd.frame_disarm = 1'b1;
                     end else begin
                        cmd.frame_arm = 1'b1;
                        state_in      = ST_DECAY;
                     end
                  end
                  KIND_TRACK: begin
                     if (!status.armed || status.req_id_neg) begin
                        state_in = ST_IGNORE;
                     end else begin
                        state_in = ST_TRK_PREP;
                     end
                  end
                  KIND_READ: state_in = ST_QRY_RD;
                  default: ;
               endcase
            end
         end
         ST_DECAY: begin
            cmd.mem_op = MEM_DECAY;
            if (status.sweep_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_TRK_PREP: begin
            cmd.foot_load = 1'b1;
            state_in      = ST_TRK_LOAD;
         end
         ST_TRK_LOAD: begin
            cmd.div_load = 1'b1;
            div_cnt_in   = '0;
            state_in     = ST_TRK_DIV;
         end
         ST_TRK_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_TRK_RD;
            end
         end
         ST_TRK_RD: begin
            cmd.mem_op = MEM_RD_TRACK;
            state_in   = ST_TRK_WR;
         end
         ST_TRK_WR: begin
            if (status.out_free) begin
               cmd.mem_op   = MEM_INC;
               cmd.out_load = 1'b1;
               cmd.out_src  = OUT_TRACK;
               state_in     = ST_IDLE;
            end
         end
         ST_IGNORE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = OUT_IGNORE;
               state_in     = ST_IDLE;
            end
         end
         ST_QRY_RD: begin
            cmd.mem_op = MEM_RD_QUERY;
            state_in   = ST_QRY_OUT;
         end
         ST_QRY_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = OUT_READ;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: sv/dog_checker.sv
// Port-level checks of the occupancy grid core, attached by bind.
// Depends on dog_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dog_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [1:0]                    req_kind,
   input logic [dog_pkg::PIX_W-1:0]     req_frame_width,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [dog_pkg::VALUE_W-1:0]   rsp_cell_value,
   input logic                          rsp_counted,
   input logic                          rsp_saturated
);
   import dog_pkg::*;

   // the clearing pass holds off requests right after reset
   `DOG_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> req_stall, "no clear pass after reset")

   // a stalled result holds
   `DOG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_value), "stalled result changed")

   // saturation only on a counted track, at full scale
   `DOG_ASSERT(a_sat_full, clock, reset, rsp_valid && rsp_saturated |-> rsp_counted && (rsp_cell_value == VALUE_MAX), "bad saturated result")

   // a counted cell holds at least one full count
   `DOG_ASSERT(a_counted_min, clock, reset, rsp_valid && rsp_counted |-> rsp_cell_value >= VALUE_ONE, "counted cell below one")

   // a zero-width frame disarms without a decay sweep
   `DOG_ASSERT(a_bad_frame_fast, clock, reset, req_valid && !req_stall && (req_kind == KIND_FRAME) && (req_frame_width == '0) |=> !req_stall, "zero frame started a sweep")

endmodule

bind decaying_occupancy_grid_core dog_checker u_checker (.*);
